### hdl/bld_pkg.sv
// Package for the decimal long divider: sizes, digit type, status codes,
// state and remainder-unit control types. No dependencies.
`default_nettype none

package bld_pkg;

  localparam int MAX_DIGITS  = 30;
  localparam int QUOT_DIGITS = 30;
  localparam int NPOS        = MAX_DIGITS + 1;
  localparam int LEN_W       = $clog2(MAX_DIGITS + 1);
  localparam int AIDX_W      = $clog2(MAX_DIGITS);
  localparam int DCNT_W      = $clog2(QUOT_DIGITS);
  localparam int EXP_W       = 18;

  localparam logic signed [EXP_W-1:0] EXP_LIMIT = 18'sd99999;

  typedef logic [3:0] digit_t;

  localparam digit_t DIGIT_MAX  = 4'd9;
  localparam digit_t DIGIT_BASE = 4'd10;

  localparam logic CMD_DIVIDEND = 1'b0;
  localparam logic CMD_DIVISOR  = 1'b1;

  typedef enum logic [2:0] {
    ST_OK            = 3'd0,
    ST_DIV_ZERO      = 3'd1,
    ST_ZERO_DIVIDEND = 3'd2,
    ST_EXP_RANGE     = 3'd3,
    ST_TOO_LONG      = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_CLEAR,
    S_LOAD,
    S_TEST,
    S_ADJUST,
    S_ECHECK,
    S_DIGIT,
    S_PASS,
    S_DECIDE,
    S_EMIT,
    S_STATUS
  } state_e;

  typedef enum logic [2:0] {
    OP_HOLD,
    OP_LOAD_DIV,
    OP_CLEAR,
    OP_BRING,
    OP_ROTATE,
    OP_COMMIT
  } rem_op_e;

  typedef struct packed {
    rem_op_e          op;
    digit_t           digit;
    logic [LEN_W-1:0] top;
    logic             first_pos;
    logic             last_pos;
  } rem_ctrl_t;

endpackage

`default_nettype wire

### hdl/bld_rem_unit.sv
// Remainder unit: divisor, remainder and difference digit shift registers
// with a one-digit serial subtractor. Depends on bld_pkg.
`default_nettype none

module bld_rem_unit import bld_pkg::*; (
  input  wire logic      clk_i,
  input  wire logic      rst_ni,
  input  wire rem_ctrl_t ctrl_i,
  output logic           borrow_o
);

  digit_t r_q  [NPOS];
  digit_t r_d  [NPOS];
  digit_t b_q  [NPOS];
  digit_t b_d  [NPOS];
  digit_t dd_q [NPOS];
  digit_t dd_d [NPOS];
  digit_t r_up [NPOS];
  digit_t b_up [NPOS];
  digit_t dd_up[NPOS];
  digit_t r_dn [NPOS];
  digit_t b_dn [NPOS];

  logic   bor_q, bor_d;
  digit_t bdig;
  digit_t ddig;
  logic   bin;
  logic [4:0] t;

  always_comb begin
    for (int j = 0; j < NPOS - 1; j++) begin
      r_up[j]  = r_q[j+1];
      b_up[j]  = b_q[j+1];
      dd_up[j] = dd_q[j+1];
    end
    r_up[NPOS-1]  = r_q[0];
    b_up[NPOS-1]  = b_q[0];
    dd_up[NPOS-1] = dd_q[0];
    r_dn[0] = ctrl_i.digit;
    b_dn[0] = ctrl_i.digit;
    for (int j = 1; j < NPOS; j++) begin
      r_dn[j] = r_q[j-1];
      b_dn[j] = b_q[j-1];
    end
  end

  always_comb begin
    bdig = ctrl_i.last_pos ? '0 : b_q[0];
    bin  = ctrl_i.first_pos ? 1'b0 : bor_q;
    t    = {1'b0, r_q[0]} - {1'b0, bdig} - {4'b0000, bin};
    ddig = t[4] ? t[3:0] + DIGIT_BASE : t[3:0];
  end

  always_comb begin
    r_d   = r_q;
    b_d   = b_q;
    dd_d  = dd_q;
    bor_d = bor_q;
    case (ctrl_i.op)
      OP_LOAD_DIV: begin
        b_d = b_dn;
      end
      OP_CLEAR: begin
        for (int j = 0; j < NPOS; j++) begin
          r_d[j] = '0;
        end
      end
      OP_BRING: begin
        for (int j = 0; j < NPOS; j++) begin
          if (LEN_W'(j) <= ctrl_i.top) begin
            r_d[j] = r_dn[j];
          end
        end
      end
      OP_ROTATE: begin
        bor_d = t[4];
        for (int j = 0; j < NPOS; j++) begin
          if (LEN_W'(j) == ctrl_i.top) begin
            r_d[j]  = r_q[0];
            b_d[j]  = b_q[0];
            dd_d[j] = ddig;
          end else if (LEN_W'(j) < ctrl_i.top) begin
            r_d[j]  = r_up[j];
            b_d[j]  = b_up[j];
            dd_d[j] = dd_up[j];
          end
        end
      end
      OP_COMMIT: begin
        r_d = dd_q;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bor_q <= 1'b0;
    end else begin
      bor_q <= bor_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q  <= r_d;
    b_q  <= b_d;
    dd_q <= dd_d;
  end

  assign borrow_o = bor_q;

endmodule

`default_nettype wire

### hdl/bcd_long_division.sv
// Top level of the decimal long divider: operand loading, control sequencer
// and output register. Depends on bld_pkg and bld_rem_unit.
//
//  channel | direction | handshake               | payload
//  --------+-----------+-------------------------+------------------------------------
//  in      | request   | in_valid_i / in_ready_o | cmd, digit, final_digit, negative,
//          |           |                         | divisor_exponent
//  out     | result    | out_valid_o/out_ready_i | quotient_digit, result_exponent,
//          |           |                         | result_negative, status, last_digit
//
// Dividend items and non-final divisor items leave the sequencer idle, ready for the next item.
// A final divisor item starts the division: checks, remainder load and alignment, then per
// quotient digit q a run of q + 1 trial subtractions (q for a nine); each trial subtraction is one
// digit-serial pass over LB + 1 digit positions through the remainder unit, LB being the divisor length.
// Reset clears lengths, flags and handshake state; digit stores need no clearing.
// A stalled output holds the sequencer at its next result; input is taken in idle only.
`default_nettype none

module bcd_long_division import bld_pkg::*; (
  input  wire logic                    clk_i,
  input  wire logic                    rst_ni,
  input  wire logic                    in_valid_i,
  output logic                         in_ready_o,
  input  wire logic                    cmd_i,
  input  wire logic [3:0]              digit_i,
  input  wire logic                    final_digit_i,
  input  wire logic                    negative_i,
  input  wire logic signed [EXP_W-1:0] divisor_exponent_i,
  output logic                         out_valid_o,
  input  wire logic                    out_ready_i,
  output logic [3:0]                   quotient_digit_o,
  output logic signed [EXP_W-1:0]      result_exponent_o,
  output logic                         result_negative_o,
  output logic [2:0]                   status_o,
  output logic                         last_digit_o
);

  state_e state_q, state_d;

  logic [LEN_W-1:0]  la_q, la_d;
  logic [LEN_W-1:0]  lb_q, lb_d;
  logic [LEN_W-1:0]  cnt_q, cnt_d;
  logic [DCNT_W-1:0] dcnt_q, dcnt_d;
  logic              tl_q, tl_d;
  logic              dsign_q, dsign_d;
  logic              nsign_q, nsign_d;
  logic signed [EXP_W-1:0] p_q, p_d;
  logic signed [EXP_W-1:0] e_q, e_d;
  digit_t            q_q, q_d;
  status_e           stat_q, stat_d;

  digit_t a_q [MAX_DIGITS];
  digit_t a_d [MAX_DIGITS];
  digit_t a_up[MAX_DIGITS];

  logic                    out_valid_q, out_valid_d;
  digit_t                  out_digit_q, out_digit_d;
  logic signed [EXP_W-1:0] out_exp_q, out_exp_d;
  logic                    out_neg_q, out_neg_d;
  status_e                 out_stat_q, out_stat_d;
  logic                    out_last_q, out_last_d;

  rem_ctrl_t ctrl;
  logic      borrow;
  logic      out_free;
  digit_t    dc;
  digit_t    fetch;
  logic      consume;
  logic signed [EXP_W-1:0] lae, lbe;

  function automatic logic exp_bad(input logic signed [EXP_W-1:0] x);
    return (x > EXP_LIMIT) || (x < -EXP_LIMIT);
  endfunction

  bld_rem_unit u_rem (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .ctrl_i   (ctrl),
    .borrow_o (borrow)
  );

  always_comb begin
    for (int j = 0; j < MAX_DIGITS - 1; j++) begin
      a_up[j] = a_q[j+1];
    end
    a_up[MAX_DIGITS-1] = a_q[MAX_DIGITS-1];
  end

  assign in_ready_o = (state_q == S_IDLE);
  assign out_free   = !out_valid_q || out_ready_i;
  assign dc         = (digit_i > DIGIT_MAX) ? DIGIT_MAX : digit_i;
  assign fetch      = (la_q != '0) ? a_q[0] : '0;
  assign lae        = $signed({{(EXP_W-LEN_W){1'b0}}, la_q});
  assign lbe        = $signed({{(EXP_W-LEN_W){1'b0}}, lb_q});

  always_comb begin
    state_d     = state_q;
    la_d        = la_q;
    lb_d        = lb_q;
    cnt_d       = cnt_q;
    dcnt_d      = dcnt_q;
    tl_d        = tl_q;
    dsign_d     = dsign_q;
    nsign_d     = nsign_q;
    p_d         = p_q;
    e_d         = e_q;
    q_d         = q_q;
    stat_d      = stat_q;
    a_d         = a_q;
    consume     = 1'b0;
    out_valid_d = out_valid_q && !out_ready_i;
    out_digit_d = out_digit_q;
    out_exp_d   = out_exp_q;
    out_neg_d   = out_neg_q;
    out_stat_d  = out_stat_q;
    out_last_d  = out_last_q;
    ctrl.op        = OP_HOLD;
    ctrl.digit     = fetch;
    ctrl.top       = lb_q;
    ctrl.first_pos = (cnt_q == '0);
    ctrl.last_pos  = (cnt_q == lb_q);

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          if (cmd_i == CMD_DIVIDEND) begin
            if (la_q != '0 || dc != '0) begin
              if (la_q >= LEN_W'(MAX_DIGITS)) begin
                tl_d = 1'b1;
              end else begin
                a_d[la_q[AIDX_W-1:0]] = dc;
                la_d = la_q + LEN_W'(1);
              end
            end
            if (final_digit_i) begin
              dsign_d = negative_i;
            end
          end else begin
            if (lb_q != '0 || dc != '0) begin
              if (lb_q >= LEN_W'(MAX_DIGITS)) begin
                tl_d = 1'b1;
              end else begin
                ctrl.op    = OP_LOAD_DIV;
                ctrl.digit = dc;
                lb_d       = lb_q + LEN_W'(1);
              end
            end
            if (final_digit_i) begin
              p_d     = divisor_exponent_i;
              nsign_d = negative_i;
              state_d = S_CHECK;
            end
          end
        end
      end
      S_CHECK: begin
        if (tl_q) begin
          stat_d  = ST_TOO_LONG;
          state_d = S_STATUS;
        end else if (exp_bad(p_q)) begin
          stat_d  = ST_EXP_RANGE;
          state_d = S_STATUS;
        end else if (lb_q == '0) begin
          stat_d  = ST_DIV_ZERO;
          state_d = S_STATUS;
        end else if (la_q == '0) begin
          stat_d  = ST_ZERO_DIVIDEND;
          state_d = S_STATUS;
        end else begin
          state_d = S_CLEAR;
        end
      end
      S_CLEAR: begin
        ctrl.op = OP_CLEAR;
        e_d     = lae - lbe + EXP_W'(1) - p_q;
        cnt_d   = '0;
        state_d = S_LOAD;
      end
      S_LOAD: begin
        ctrl.op = OP_BRING;
        consume = 1'b1;
        if (cnt_q == lb_q - LEN_W'(1)) begin
          cnt_d   = '0;
          state_d = S_TEST;
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
      end
      S_TEST: begin
        ctrl.op = OP_ROTATE;
        if (cnt_q == lb_q) begin
          cnt_d   = '0;
          state_d = S_ADJUST;
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
      end
      S_ADJUST: begin
        if (borrow) begin
          ctrl.op = OP_BRING;
          consume = 1'b1;
          e_d     = e_q - EXP_W'(1);
        end
        state_d = S_ECHECK;
      end
      S_ECHECK: begin
        if (exp_bad(e_q)) begin
          stat_d  = ST_EXP_RANGE;
          state_d = S_STATUS;
        end else begin
          q_d     = '0;
          dcnt_d  = '0;
          state_d = S_DIGIT;
        end
      end
      S_DIGIT: begin
        cnt_d = '0;
        if (q_q == DIGIT_MAX) begin
          state_d = S_EMIT;
        end else begin
          state_d = S_PASS;
        end
      end
      S_PASS: begin
        ctrl.op = OP_ROTATE;
        if (cnt_q == lb_q) begin
          state_d = S_DECIDE;
        end else begin
          cnt_d = cnt_q + LEN_W'(1);
        end
      end
      S_DECIDE: begin
        if (!borrow) begin
          ctrl.op = OP_COMMIT;
          q_d     = q_q + 4'd1;
          state_d = S_DIGIT;
        end else begin
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_digit_d = q_q;
          out_exp_d   = e_q;
          out_neg_d   = dsign_q ^ nsign_q;
          out_stat_d  = ST_OK;
          out_last_d  = (dcnt_q == DCNT_W'(QUOT_DIGITS - 1));
          if (dcnt_q == DCNT_W'(QUOT_DIGITS - 1)) begin
            la_d    = '0;
            lb_d    = '0;
            dsign_d = 1'b0;
            tl_d    = 1'b0;
            state_d = S_IDLE;
          end else begin
            ctrl.op = OP_BRING;
            consume = 1'b1;
            dcnt_d  = dcnt_q + DCNT_W'(1);
            q_d     = '0;
            state_d = S_DIGIT;
          end
        end
      end
      S_STATUS: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          out_digit_d = '0;
          out_exp_d   = '0;
          out_neg_d   = 1'b0;
          out_stat_d  = stat_q;
          out_last_d  = 1'b1;
          la_d        = '0;
          lb_d        = '0;
          dsign_d     = 1'b0;
          tl_d        = 1'b0;
          state_d     = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase

    if (consume && la_q != '0) begin
      a_d  = a_up;
      la_d = la_q - LEN_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      la_q        <= '0;
      lb_q        <= '0;
      cnt_q       <= '0;
      dcnt_q      <= '0;
      tl_q        <= 1'b0;
      dsign_q     <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      la_q        <= la_d;
      lb_q        <= lb_d;
      cnt_q       <= cnt_d;
      dcnt_q      <= dcnt_d;
      tl_q        <= tl_d;
      dsign_q     <= dsign_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    nsign_q     <= nsign_d;
    p_q         <= p_d;
    e_q         <= e_d;
    q_q         <= q_d;
    stat_q      <= stat_d;
    out_digit_q <= out_digit_d;
    out_exp_q   <= out_exp_d;
    out_neg_q   <= out_neg_d;
    out_stat_q  <= out_stat_d;
    out_last_q  <= out_last_d;
  end

  assign out_valid_o       = out_valid_q;
  assign quotient_digit_o  = out_digit_q;
  assign result_exponent_o = out_exp_q;
  assign result_negative_o = out_neg_q;
  assign status_o          = out_stat_q;
  assign last_digit_o      = out_last_q;

endmodule

`default_nettype wire

### hdl/bld_checker.sv
// Port-level checker for the decimal long divider, bound to the top level.
// Depends on bld_pkg.
`default_nettype none

module bld_checker import bld_pkg::*; (
  input wire logic                    clk_i,
  input wire logic                    rst_ni,
  input wire logic                    in_valid_i,
  input wire logic                    in_ready_o,
  input wire logic                    cmd_i,
  input wire logic                    final_digit_i,
  input wire logic                    out_valid_o,
  input wire logic                    out_ready_i,
  input wire logic [3:0]              quotient_digit_o,
  input wire logic signed [EXP_W-1:0] result_exponent_o,
  input wire logic                    result_negative_o,
  input wire logic [2:0]              status_o,
  input wire logic                    last_digit_o
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(quotient_digit_o)
      && $stable(result_exponent_o) && $stable(status_o) && $stable(last_digit_o))
    else $error("result changed while stalled");

  a_status_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && status_o != ST_OK |-> last_digit_o && quotient_digit_o == 4'd0
      && result_exponent_o == '0 && !result_negative_o)
    else $error("status result malformed");

  a_digit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> quotient_digit_o <= DIGIT_MAX)
    else $error("quotient digit above nine");

  a_busy_after_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_o && cmd_i == CMD_DIVISOR && final_digit_i |=> !in_ready_o)
    else $error("request taken during division");

endmodule

bind bcd_long_division bld_checker u_bld_checker (.*);

`default_nettype wire

### test/bcd_long_division_tb.sv
// Testbench for bcd_long_division: drives dividend and divisor digit requests,
// predicts every quotient digit and status result, and checks them in order.
// Depends on bld_pkg and the bcd_long_division RTL.
`timescale 1ns / 1ps

module bcd_long_division_tb;
  import bld_pkg::*;

  localparam int ITEMS_PER_PHASE = 60;
  localparam int HOLD_OFF_CYCLES = 1500;
  localparam int QUIET_LIMIT     = 20000;
  localparam int SETTLE_CYCLES   = 400;

  localparam logic signed [EXP_W-1:0] EXP_OVER     = EXP_LIMIT + 18'sd1;
  localparam logic signed [EXP_W-1:0] EXP_FLOOR    = -EXP_LIMIT;
  localparam logic signed [EXP_W-1:0] EXP_MOST_NEG = {1'b1, {(EXP_W-1){1'b0}}};

  typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_e;

  typedef struct {
    logic                    cmd;
    digit_t                  digit;
    logic                    final_digit;
    logic                    negative;
    logic signed [EXP_W-1:0] divisor_exponent;
  } request_t;

  typedef struct {
    digit_t                  quotient_digit;
    logic signed [EXP_W-1:0] result_exponent;
    logic                    result_negative;
    status_e                 status;
    logic                    last_digit;
  } quotient_t;

  typedef struct {
    request_t req;
    int       reps;
    logic     typed;
    status_e  want;
  } plan_row_t;

  logic                    clk_i = 1'b0;
  logic                    rst_ni = 1'b0;
  logic                    in_valid_i = 1'b0;
  logic                    in_ready_o;
  logic                    cmd_i = CMD_DIVIDEND;
  logic [3:0]              digit_i = '0;
  logic                    final_digit_i = 1'b0;
  logic                    negative_i = 1'b0;
  logic signed [EXP_W-1:0] divisor_exponent_i = '0;
  logic                    out_valid_o;
  logic                    out_ready_i = 1'b0;
  logic [3:0]              quotient_digit_o;
  logic signed [EXP_W-1:0] result_exponent_o;
  logic                    result_negative_o;
  logic [2:0]              status_o;
  logic                    last_digit_o;

  bcd_long_division dut (.*);

  plan_row_t plan [29] = '{
    '{'{CMD_DIVISOR,  4'd0,  1'b1, 1'b0, 18'sd0},       1,  1'b1, ST_DIV_ZERO},
    '{'{CMD_DIVISOR,  4'd5,  1'b1, 1'b1, 18'sd0},       1,  1'b1, ST_ZERO_DIVIDEND},
    '{'{CMD_DIVIDEND, 4'd9,  1'b1, 1'b1, EXP_MOST_NEG}, 1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd3,  1'b1, 1'b0, EXP_LIMIT},    1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd7,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd2,  1'b1, 1'b0, EXP_OVER},     1,  1'b1, ST_EXP_RANGE},
    '{'{CMD_DIVIDEND, 4'd7,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd2,  1'b1, 1'b1, EXP_MOST_NEG}, 1,  1'b1, ST_EXP_RANGE},
    '{'{CMD_DIVIDEND, 4'd1,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd2,  1'b1, 1'b0, EXP_FLOOR},    1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd5,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd2,  1'b1, 1'b0, EXP_FLOOR},    1,  1'b1, ST_EXP_RANGE},
    '{'{CMD_DIVIDEND, 4'd15, 1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd12, 1'b1, 1'b1, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd9,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd1,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd0,  1'b0, 1'b0, 18'sd0},       2,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd4,  1'b1, 1'b1, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd0,  1'b0, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd2,  1'b1, 1'b1, -18'sd3},      1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd3,  1'b1, 1'b1, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd4,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd1,  1'b0, 1'b0, EXP_OVER},     1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd7,  1'b1, 1'b0, 18'sd1},       1,  1'b0, ST_OK},
    '{'{CMD_DIVIDEND, 4'd1,  1'b0, 1'b0, 18'sd0},       31, 1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd3,  1'b1, 1'b0, 18'sd0},       1,  1'b1, ST_TOO_LONG},
    '{'{CMD_DIVIDEND, 4'd8,  1'b1, 1'b0, 18'sd0},       1,  1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd9,  1'b0, 1'b0, 18'sd0},       30, 1'b0, ST_OK},
    '{'{CMD_DIVISOR,  4'd9,  1'b1, 1'b0, 18'sd0},       1,  1'b1, ST_TOO_LONG}
  };

  quotient_t quotient_q[$];
  quotient_t fresh_q[$];
  idle_e     idle_mode = IDLE_NONE;
  logic      holding = 1'b0;
  event      hold_off_go;
  int        items_sent = 0;
  int        mismatches = 0;
  int        quiet_cycles = 0;

  // operand stores indexed by cmd: CMD_DIVIDEND or CMD_DIVISOR
  digit_t op_digits [2][MAX_DIGITS];
  int     op_len [2] = '{0, 0};
  logic   num_neg = 1'b0;
  logic   overflow_seen = 1'b0;
  digit_t part_rem [NPOS];
  int     part_w = 1;

  function automatic digit_t dividend_at(int k);
    return (k < op_len[CMD_DIVIDEND]) ? op_digits[CMD_DIVIDEND][k] : 4'd0;
  endfunction

  function automatic digit_t divisor_at(int i);
    if (i == 0 || i > op_len[CMD_DIVISOR]) return 4'd0;
    return op_digits[CMD_DIVISOR][i-1];
  endfunction

  function automatic logic rem_fits();
    digit_t b;
    for (int i = 0; i < part_w; i++) begin
      b = divisor_at(i);
      if (part_rem[i] != b) return part_rem[i] > b;
    end
    return 1'b1;
  endfunction

  function automatic void rem_subtract();
    int t;
    int borrow;
    borrow = 0;
    for (int i = part_w - 1; i >= 0; i--) begin
      t = int'(part_rem[i]) - int'(divisor_at(i)) - borrow;
      borrow = (t < 0) ? 1 : 0;
      if (t < 0) t += 10;
      part_rem[i] = digit_t'(t);
    end
  endfunction

  function automatic void rem_shift(digit_t d);
    for (int i = 0; i + 1 < part_w; i++) part_rem[i] = part_rem[i+1];
    part_rem[part_w-1] = d;
  endfunction

  task automatic predict_quotient(input request_t r);
    digit_t    d;
    digit_t    q;
    int        p;
    int        e;
    int        nxt;
    logic      sgn;
    status_e   st;
    quotient_t res;
    d = (r.digit > DIGIT_MAX) ? DIGIT_MAX : r.digit;
    if (!(op_len[r.cmd] == 0 && d == 4'd0)) begin
      if (op_len[r.cmd] >= MAX_DIGITS) begin
        overflow_seen = 1'b1;
      end else begin
        op_digits[r.cmd][op_len[r.cmd]] = d;
        op_len[r.cmd]++;
      end
    end
    if (r.cmd == CMD_DIVIDEND) begin
      if (r.final_digit) num_neg = r.negative;
      return;
    end
    if (!r.final_digit) return;
    p = int'(r.divisor_exponent);
    e = op_len[CMD_DIVIDEND] - op_len[CMD_DIVISOR] - p + 1;
    st = ST_OK;
    if (overflow_seen) begin
      st = ST_TOO_LONG;
    end else if (p > EXP_LIMIT || p < -EXP_LIMIT) begin
      st = ST_EXP_RANGE;
    end else if (op_len[CMD_DIVISOR] == 0) begin
      st = ST_DIV_ZERO;
    end else if (op_len[CMD_DIVIDEND] == 0) begin
      st = ST_ZERO_DIVIDEND;
    end else begin
      part_w = op_len[CMD_DIVISOR] + 1;
      part_rem[0] = 4'd0;
      for (int k = 0; k < op_len[CMD_DIVISOR]; k++) part_rem[k+1] = dividend_at(k);
      nxt = op_len[CMD_DIVISOR];
      if (!rem_fits()) begin
        rem_shift(dividend_at(nxt));
        nxt++;
        e--;
      end
      if (e > EXP_LIMIT || e < -EXP_LIMIT) st = ST_EXP_RANGE;
    end
    if (st != ST_OK) begin
      res = '{4'd0, 18'sd0, 1'b0, st, 1'b1};
      fresh_q.push_back(res);
    end else begin
      sgn = num_neg ^ r.negative;
      for (int k = 0; k < QUOT_DIGITS; k++) begin
        q = 4'd0;
        while (q < DIGIT_MAX && rem_fits()) begin
          rem_subtract();
          q++;
        end
        res.quotient_digit  = q;
        res.result_exponent = e[EXP_W-1:0];
        res.result_negative = sgn;
        res.status          = ST_OK;
        res.last_digit      = (k == QUOT_DIGITS - 1);
        fresh_q.push_back(res);
        rem_shift(dividend_at(nxt));
        nxt++;
      end
    end
    op_len[CMD_DIVIDEND] = 0;
    op_len[CMD_DIVISOR]  = 0;
    num_neg              = 1'b0;
    overflow_seen        = 1'b0;
  endtask

  task automatic send_request(input request_t r, input logic typed, input status_e want);
    int        gap_pct;
    quotient_t res;
    gap_pct = (idle_mode == IDLE_SEND) ? 45 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    while ($urandom_range(99) < gap_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i         <= 1'b1;
    cmd_i              <= r.cmd;
    digit_i            <= r.digit;
    final_digit_i      <= r.final_digit;
    negative_i         <= r.negative;
    divisor_exponent_i <= r.divisor_exponent;
    do @(posedge clk_i); while (!in_ready_o);
    items_sent++;
    predict_quotient(r);
    if (typed) begin
      fresh_q.delete();
      res = '{4'd0, 18'sd0, 1'b0, want, 1'b1};
      fresh_q.push_back(res);
    end
    foreach (fresh_q[i]) quotient_q.push_back(fresh_q[i]);
    fresh_q.delete();
  endtask

  function automatic digit_t random_digit();
    return ($urandom_range(7) == 0) ? digit_t'($urandom_range(15))
                                    : digit_t'($urandom_range(9));
  endfunction

  function automatic int random_length();
    if ($urandom_range(19) == 0) return 0;
    return ($urandom_range(9) == 0) ? int'($urandom_range(20, MAX_DIGITS + 2))
                                    : int'($urandom_range(1, 6));
  endfunction

  task automatic send_random_division();
    request_t r;
    int       lead;
    int       total;
    int       n_den;
    if ($urandom_range(99) < 8) begin
      repeat ($urandom_range(1, 6)) begin
        r.cmd              = 1'($urandom_range(1));
        r.digit            = digit_t'($urandom_range(15));
        r.final_digit      = 1'($urandom_range(1));
        r.negative         = 1'($urandom_range(1));
        r.divisor_exponent = EXP_W'($urandom);
        send_request(r, 1'b0, ST_OK);
      end
      return;
    end
    lead  = ($urandom_range(3) == 0) ? int'($urandom_range(1, 2)) : 0;
    total = lead + random_length();
    for (int i = 0; i < total; i++) begin
      r.cmd              = CMD_DIVIDEND;
      r.digit            = (i < lead) ? 4'd0 : random_digit();
      r.final_digit      = (i == total - 1) || ($urandom_range(11) == 0);
      r.negative         = 1'($urandom_range(1));
      r.divisor_exponent = EXP_W'($urandom);
      send_request(r, 1'b0, ST_OK);
    end
    lead  = ($urandom_range(3) == 0) ? int'($urandom_range(1, 2)) : 0;
    n_den = random_length();
    total = lead + ((n_den == 0) ? 1 : n_den);
    for (int i = 0; i < total; i++) begin
      r.cmd         = CMD_DIVISOR;
      r.digit       = (i < lead || n_den == 0) ? 4'd0 : random_digit();
      r.final_digit = (i == total - 1);
      r.negative    = 1'($urandom_range(1));
      if (i < total - 1) begin
        r.divisor_exponent = EXP_W'($urandom);
      end else begin
        case ($urandom_range(9))
          0:       r.divisor_exponent = EXP_W'($urandom);
          1:       r.divisor_exponent = EXP_LIMIT - 18'sd1 + EXP_W'($urandom_range(2));
          2:       r.divisor_exponent = EXP_FLOOR + 18'sd1 - EXP_W'($urandom_range(2));
          default: r.divisor_exponent = EXP_W'($urandom_range(40)) - 18'sd20;
        endcase
      end
      send_request(r, 1'b0, ST_OK);
    end
  endtask

  initial forever #6 clk_i = ~clk_i;

  initial forever begin
    @(hold_off_go);
    holding <= 1'b1;
    repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
    holding <= 1'b0;
  end

  always @(posedge clk_i) begin
    quotient_t want;
    int        stall_pct;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (quotient_q.size() == 0) begin
        $error("result with no request pending: quotient_digit %0d status %0d",
               quotient_digit_o, status_o);
        mismatches++;
      end else begin
        want = quotient_q.pop_front();
        if (quotient_digit_o !== want.quotient_digit) begin
          $error("quotient_digit: expected %0d, got %0d", want.quotient_digit,
                 quotient_digit_o);
          mismatches++;
        end
        if (result_exponent_o !== want.result_exponent) begin
          $error("result_exponent: expected %0d, got %0d", want.result_exponent,
                 result_exponent_o);
          mismatches++;
        end
        if (result_negative_o !== want.result_negative) begin
          $error("result_negative: expected %0d, got %0d", want.result_negative,
                 result_negative_o);
          mismatches++;
        end
        if (status_o !== want.status) begin
          $error("status: expected %0d, got %0d", want.status, status_o);
          mismatches++;
        end
        if (last_digit_o !== want.last_digit) begin
          $error("last_digit: expected %0d, got %0d", want.last_digit, last_digit_o);
          mismatches++;
        end
      end
    end
    stall_pct = (idle_mode == IDLE_RECV) ? 45 : (idle_mode == IDLE_BOTH) ? 29 : 0;
    out_ready_i <= !holding && ($urandom_range(99) >= stall_pct);
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) quiet_cycles = 0;
    else quiet_cycles++;
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  initial begin
    idle_e phase_idle [6];
    int    target;
    phase_idle = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH, IDLE_NONE, IDLE_BOTH};
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    foreach (plan[i])
      repeat (plan[i].reps) send_request(plan[i].req, plan[i].typed, plan[i].want);

    for (int ph = 0; ph < 6; ph++) begin
      idle_mode = phase_idle[ph];
      target    = items_sent + ITEMS_PER_PHASE;
      // hold the result side off while requests keep coming
      if (ph == 4) -> hold_off_go;
      while (items_sent < target) begin
        send_random_division();
        // drain before the next division
        if (ph == 5 && quotient_q.size() != 0) begin
          in_valid_i <= 1'b0;
          while (quotient_q.size() != 0) @(posedge clk_i);
        end
      end
    end

    in_valid_i <= 1'b0;
    while (quotient_q.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
